/* rtl/vga_text_port_registers_macros.svh */
// ----------------------------------------------------------------------------
// vga_text_port_registers_macros.svh
// assertion macros for the vga text port register block
// ----------------------------------------------------------------------------
`ifndef VGA_TEXT_PORT_REGISTERS_MACROS_SVH
`define VGA_TEXT_PORT_REGISTERS_MACROS_SVH

`ifndef SYNTHESIS

`define VTP_ASSERT_SAME(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("vtp assertion failed");

`define VTP_ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("vtp assertion failed");

`else

`define VTP_ASSERT_SAME(label, clk, rst_n, a, b)

`define VTP_ASSERT_NEXT(label, clk, rst_n, a, b)

`endif

`endif

/* rtl/vtp_pkg.sv */
// ----------------------------------------------------------------------------
// vtp_pkg
// shared codes, constants and types of the vga text port register block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package vtp_pkg;

  localparam logic [2:0] CMD_STATUS_READ = 3'd0;
  localparam logic [2:0] CMD_ATTR_WRITE  = 3'd1;
  localparam logic [2:0] CMD_ATTR_READ   = 3'd2;
  localparam logic [2:0] CMD_CRT_INDEX   = 3'd3;
  localparam logic [2:0] CMD_CRT_WRITE   = 3'd4;
  localparam logic [2:0] CMD_CRT_READ    = 3'd5;

  localparam int unsigned VIDEO_BIT   = 5;
  localparam int unsigned MODE_SEL_BIT = 4;
  localparam logic [4:0]  MODE_SELECT = 5'h10;
  localparam logic [7:0]  MODE_RESET  = 8'h08 | 8'h20;

  localparam logic [7:0] CRT_CUR_START = 8'h0A;
  localparam logic [7:0] CRT_CUR_END   = 8'h0B;
  localparam logic [7:0] CRT_CUR_HIGH  = 8'h0E;
  localparam logic [7:0] CRT_CUR_LOW   = 8'h0F;

  typedef struct packed {
    logic [7:0]  read_data;
    logic [7:0]  mode;
    logic [15:0] cursor;
    logic [7:0]  cursor_start;
    logic [7:0]  cursor_end;
  } result_t;

endpackage

/* rtl/vtp_regs.sv */
// ----------------------------------------------------------------------------
// vtp_regs
// attribute controller and crt cursor registers, one request per enable
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vtp_regs (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic [2:0]       cmd,
  input  logic [7:0]       data,
  output vtp_pkg::result_t result
);

  logic        idx_pend_r, idx_pend_nxt;
  logic [4:0]  attr_index_r, attr_index_nxt;
  logic        vbit_pend_r, vbit_pend_nxt;
  logic [7:0]  mode_r, mode_nxt;
  logic [7:0]  crt_index_r, crt_index_nxt;
  logic [7:0]  cur_start_r, cur_start_nxt;
  logic [7:0]  cur_end_r, cur_end_nxt;
  logic [15:0] cursor_r, cursor_nxt;
  logic [7:0]  rd;

  always_comb begin
    idx_pend_nxt   = idx_pend_r;
    attr_index_nxt = attr_index_r;
    vbit_pend_nxt  = vbit_pend_r;
    mode_nxt       = mode_r;
    crt_index_nxt  = crt_index_r;
    cur_start_nxt  = cur_start_r;
    cur_end_nxt    = cur_end_r;
    cursor_nxt     = cursor_r;
    rd             = 8'h00;
    case (cmd)
      vtp_pkg::CMD_STATUS_READ: begin
        idx_pend_nxt = 1'b1;
      end
      vtp_pkg::CMD_ATTR_WRITE: begin
        if (idx_pend_r) begin
          attr_index_nxt = data[4:0];
          if (data[vtp_pkg::VIDEO_BIT]) begin
            vbit_pend_nxt = 1'b1;
          end
          idx_pend_nxt = 1'b0;
        end else if (attr_index_r[vtp_pkg::MODE_SEL_BIT]) begin
          mode_nxt = data;
          mode_nxt[vtp_pkg::VIDEO_BIT] = vbit_pend_r | data[vtp_pkg::VIDEO_BIT];
          vbit_pend_nxt = 1'b0;
        end
      end
      vtp_pkg::CMD_ATTR_READ: begin
        if (!idx_pend_r && attr_index_r == vtp_pkg::MODE_SELECT) begin
          attr_index_nxt = 5'd0;
          rd = mode_r;
        end else begin
          idx_pend_nxt  = 1'b0;
          vbit_pend_nxt = 1'b0;
        end
      end
      vtp_pkg::CMD_CRT_INDEX: begin
        crt_index_nxt = data;
      end
      vtp_pkg::CMD_CRT_WRITE: begin
        case (crt_index_r)
          vtp_pkg::CRT_CUR_START: cur_start_nxt = data;
          vtp_pkg::CRT_CUR_END:   cur_end_nxt = data;
          vtp_pkg::CRT_CUR_HIGH:  cursor_nxt = {data, cursor_r[7:0]};
          vtp_pkg::CRT_CUR_LOW:   cursor_nxt = {cursor_r[15:8], data};
          default: ;
        endcase
      end
      vtp_pkg::CMD_CRT_READ: begin
        case (crt_index_r)
          vtp_pkg::CRT_CUR_START: rd = cur_start_r;
          vtp_pkg::CRT_CUR_HIGH:  rd = cursor_r[15:8];
          vtp_pkg::CRT_CUR_LOW:   rd = cursor_r[7:0];
          default:                rd = 8'h00;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_pend_r   <= 1'b0;
      attr_index_r <= 5'd0;
      vbit_pend_r  <= 1'b0;
      mode_r       <= vtp_pkg::MODE_RESET;
      crt_index_r  <= 8'h00;
      cur_start_r  <= 8'h00;
      cur_end_r    <= 8'h00;
      cursor_r     <= 16'h0000;
    end else if (en) begin
      idx_pend_r   <= idx_pend_nxt;
      attr_index_r <= attr_index_nxt;
      vbit_pend_r  <= vbit_pend_nxt;
      mode_r       <= mode_nxt;
      crt_index_r  <= crt_index_nxt;
      cur_start_r  <= cur_start_nxt;
      cur_end_r    <= cur_end_nxt;
      cursor_r     <= cursor_nxt;
    end
  end

  assign result.read_data    = rd;
  assign result.mode         = mode_nxt;
  assign result.cursor       = cursor_nxt;
  assign result.cursor_start = cur_start_nxt;
  assign result.cursor_end   = cur_end_nxt;

endmodule

/* rtl/vtp_out.sv */
// ----------------------------------------------------------------------------
// vtp_out
// result register with valid and stall toward the result channel
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vtp_out (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  vtp_pkg::result_t result_in,
  input  logic             out_stall,
  output logic             free,
  output logic             out_valid,
  output vtp_pkg::result_t result_out
);

  logic             valid_r, valid_nxt;
  vtp_pkg::result_t res_r;

  assign free      = !valid_r || !out_stall;
  assign valid_nxt = load || (valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= result_in;
    end
  end

  assign out_valid  = valid_r;
  assign result_out = res_r;

endmodule

/* rtl/vga_text_port_registers.sv */
// ----------------------------------------------------------------------------
// vga_text_port_registers
// vga text adapter port registers: attribute mode and crt cursor
//
//   channel | role   | ports
//   --------+--------+------------------------------------------------------
//   in      | sink   | in_valid, in_stall, in_cmd, in_data
//   out     | source | out_valid, out_stall, out_read_data, out_mode_out,
//           |        | out_cursor_out, out_cursor_start_out, out_cursor_end_out
//
// one request per cycle sustained while out_stall is low; stages are the input
// register, then result register, with the register update done in the pass between them
// synchronous active-low reset clears both stages and loads mode 0x28
// a stalled result holds in the result register while the input register
// still takes one more request; in_stall rises only when both are full
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "vga_text_port_registers_macros.svh"

module vga_text_port_registers (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_cmd,
  input  logic [7:0]  in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_read_data,
  output logic [7:0]  out_mode_out,
  output logic [15:0] out_cursor_out,
  output logic [7:0]  out_cursor_start_out,
  output logic [7:0]  out_cursor_end_out
);

  logic             in_v_r, in_v_nxt;
  logic [2:0]       in_cmd_r;
  logic [7:0]       in_data_r;
  logic             out_free;
  logic             adv;
  logic             in_acc;
  vtp_pkg::result_t res_comb;
  vtp_pkg::result_t res_q;

  assign adv      = in_v_r && out_free;
  assign in_stall = in_v_r && !out_free;
  assign in_acc   = in_valid && !in_stall;
  assign in_v_nxt = in_acc || (in_v_r && !adv);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else begin
      in_v_r <= in_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_cmd_r  <= in_cmd;
      in_data_r <= in_data;
    end
  end

  vtp_regs u_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (adv),
    .cmd    (in_cmd_r),
    .data   (in_data_r),
    .result (res_comb)
  );

  vtp_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (adv),
    .result_in  (res_comb),
    .out_stall  (out_stall),
    .free       (out_free),
    .out_valid  (out_valid),
    .result_out (res_q)
  );

  assign out_read_data        = res_q.read_data;
  assign out_mode_out         = res_q.mode;
  assign out_cursor_out       = res_q.cursor;
  assign out_cursor_start_out = res_q.cursor_start;
  assign out_cursor_end_out   = res_q.cursor_end;

  `VTP_ASSERT_NEXT(a_in_held, clk, rst_n, in_v_r && !adv, in_v_r)
  `VTP_ASSERT_NEXT(a_adv_out, clk, rst_n, adv, out_valid)
  `VTP_ASSERT_NEXT(a_acc_in, clk, rst_n, in_acc, in_v_r)
  `VTP_ASSERT_SAME(a_stall_full, clk, rst_n, in_stall, in_v_r && out_valid && out_stall)

endmodule
